### rtl/core/point_mass_repulsion_step_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point mass repulsion step unit
// Shared concurrent assertion forms used by the controller and top level.
// ----------------------------------------------------------------------------
`ifndef POINT_MASS_REPULSION_STEP_UNIT_MACROS_SVH
`define POINT_MASS_REPULSION_STEP_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define PMR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PMR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/pmr_pkg.sv
// ----------------------------------------------------------------------------
// pmr_pkg
// Types, constants and command encodings for the point mass repulsion step.
// ----------------------------------------------------------------------------
package pmr_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int CFG_W = 31;
  localparam int IDX_W = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_OBS_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_OBS_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DAMP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INV_M   = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAIN    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RADIUS  = 3'd6;
  localparam logic [IDX_W-1:0] REG_PUSH    = 3'd7;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_SQRT, ST_REPCHK, ST_DIVD, ST_DIVR, ST_GAIN,
    ST_DIVM, ST_COMPX, ST_COMPY, ST_AXIS, ST_OUT
  } state_t;

  // datapath command
  typedef struct packed {
    logic load;      // capture item, apply home and pushes
    logic prep;      // compute dx, dy, squared distance
    logic sqrt_go;
    logic divd_go;   // 2^2F / D
    logic divr_go;   // 2^2F / R
    logic gain;      // t and q
    logic divm_go;   // t<<F / q
    logic compx_go;
    logic compy_go;
    logic axis;      // advance axis step sequence
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic busy;      // iterative unit running
    logic rep_ok;    // repulsion applies
    logic axis_done;
  } sts_t;

endpackage

### rtl/core/point_mass_repulsion_step_unit.sv
// ----------------------------------------------------------------------------
// point_mass_repulsion_step_unit
// One simulation tick per input word: pushes, obstacle repulsion, damped
// Euler step; a state word is emitted on command ticks.
//
//   channel   dir  payload
//   s_axis    in   tdata[5:0]: has_command, N, E, S, W, home_request
//   m_axis    out  tdata[127:0]: pos_x, pos_y, vel_x, vel_y
//   cfg       in   cfg_we, cfg_index[2:0], cfg_data[30:0]
//
// A tick takes longer with repulsion than without; the shared bit-serial
// divide/sqrt unit, which runs one root per tick and five divides more with
// repulsion, sets the length.
// One tick at a time; s_axis_tready is high only while the sequencer idles.
// A stalled output holds the sequencer in its final state.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`include "point_mass_repulsion_step_unit_macros.svh"
module point_mass_repulsion_step_unit
  import pmr_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // has_command, push_north, push_east, push_south, push_west, home_request
  input  logic [7:0]         s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // out_pos_x, out_pos_y, out_vel_x, out_vel_y
  output logic [127:0]       m_axis_tdata,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic idle, out_load, in_fire, out_free, has_cmd;
  logic signed [31:0] px, py, vx, vy;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (in_fire) has_cmd <= s_axis_tdata[0];
  end

  pmr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .has_cmd(has_cmd),
    .out_free(out_free), .sts(sts), .cmd(cmd), .idle(idle), .out_load(out_load)
  );

  pmr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .item(s_axis_tdata[5:0]), .cmd(cmd), .sts(sts),
    .pos_x(px), .pos_y(py), .vel_x(vx), .vel_y(vy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) m_axis_tdata <= {vy, vx, py, px};
  end

  `PMR_ASSERT_IMP(a_no_in_busy, !idle, !s_axis_tready)
  `PMR_ASSERT_NXT(a_out_valid, out_load, m_axis_tvalid)
  `PMR_ASSERT_IMP(a_load_free, out_load, out_free)

endmodule

### rtl/core/pmr_ctrl.sv
// ----------------------------------------------------------------------------
// pmr_ctrl
// Sequencer that steps the datapath through one simulation tick.
// ----------------------------------------------------------------------------
`include "point_mass_repulsion_step_unit_macros.svh"
module pmr_ctrl
  import pmr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic has_cmd,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic idle,
  output logic out_load
);

  state_t state, state_next;
  logic   go_sent;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go_sent <= 1'b0;
    end else begin
      state <= state_next;
      go_sent <= (state_next == state) && (state != ST_IDLE);
    end
  end

  logic wait_done;
  assign wait_done = go_sent && !sts.busy;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_PREP;
      ST_PREP:   state_next = ST_SQRT;
      ST_SQRT:   if (wait_done) state_next = ST_REPCHK;
      ST_REPCHK: state_next = sts.rep_ok ? ST_DIVD : ST_AXIS;
      ST_DIVD:   if (wait_done) state_next = ST_DIVR;
      ST_DIVR:   if (wait_done) state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_DIVM;
      ST_DIVM:   if (wait_done) state_next = ST_COMPX;
      ST_COMPX:  if (wait_done) state_next = ST_COMPY;
      ST_COMPY:  if (wait_done) state_next = ST_AXIS;
      ST_AXIS:   if (sts.axis_done) state_next = ST_OUT;
      ST_OUT:    if (!has_cmd || out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    out_load = 1'b0;
    idle = (state == ST_IDLE);
    unique case (state)
      ST_IDLE:   cmd.load = in_fire;
      ST_PREP:   cmd.prep = 1'b1;
      ST_SQRT:   cmd.sqrt_go = !go_sent;
      ST_REPCHK: ;
      ST_DIVD:   cmd.divd_go = !go_sent;
      ST_DIVR:   cmd.divr_go = !go_sent;
      ST_GAIN:   cmd.gain = 1'b1;
      ST_DIVM:   cmd.divm_go = !go_sent;
      ST_COMPX:  cmd.compx_go = !go_sent;
      ST_COMPY:  cmd.compy_go = !go_sent;
      ST_AXIS:   cmd.axis = 1'b1;
      ST_OUT: begin
        cmd.commit = !has_cmd || out_free;
        out_load = has_cmd && out_free;
      end
      default: ;
    endcase
  end

  `PMR_ASSERT_IMP(a_load_idle, cmd.load, state == ST_IDLE)
  `PMR_ASSERT_NXT(a_fire_prep, in_fire && idle, state == ST_PREP)
  `PMR_ASSERT_IMP(a_out_cmd, out_load, has_cmd && cmd.commit)

endmodule

### rtl/core/pmr_divsqrt.sv
// ----------------------------------------------------------------------------
// pmr_divsqrt
// Shared iterative unit: restoring 64-bit divide and 64-bit integer sqrt,
// one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module pmr_divsqrt
  import pmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start_div,
  input  logic        start_sqrt,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] res
);

  logic [6:0]  cnt;
  logic        mode_sqrt;
  logic [63:0] rem, quo, dv;
  logic [64:0] trial;
  logic [65:0] strial;
  logic [65:0] srem;

  // divide: shift one numerator bit into remainder
  assign trial  = {rem, quo[63]} - {1'b0, dv};
  // sqrt: two radicand bits per step into remainder
  assign strial = {srem[63:0], quo[63:62]} - {res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start_div || start_sqrt) begin
      busy <= 1'b1;
      mode_sqrt <= start_sqrt;
      cnt <= start_sqrt ? 7'd32 : 7'd64;
      rem <= '0;
      srem <= '0;
      quo <= num;
      dv <= den;
      res <= '0;
    end else if (busy) begin
      if (mode_sqrt) begin
        quo <= {quo[61:0], 2'b00};
        if (!strial[65]) begin
          srem <= strial;
          res <= {res[62:0], 1'b1};
        end else begin
          srem <= {srem[63:0], quo[63:62]};
          res <= {res[62:0], 1'b0};
        end
      end else begin
        quo <= {quo[62:0], !trial[64]};
        rem <= trial[64] ? {rem[62:0], quo[63]} : trial[63:0];
        res <= {quo[62:0], !trial[64]};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

endmodule

### rtl/core/pmr_datapath.sv
// ----------------------------------------------------------------------------
// pmr_datapath
// State registers, configuration, repulsion and damped Euler arithmetic.
// ----------------------------------------------------------------------------
module pmr_datapath
  import pmr_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_idx,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [5:0]         item,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y
);

  localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HOME = 64'd10 << FRAC_BITS;
  localparam logic [63:0] NUM  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] CAP  = 64'h7FFF_FFFF;
  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] SMIN = -64'sh8000_0000;

  logic [CFG_W-1:0] obs_x, obs_y, damp, inv_m, hstep, gain, radius, push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      obs_x <= '0;
      obs_y <= '0;
      damp <= CFG_W'(ONE);
      inv_m <= CFG_W'(ONE);
      hstep <= CFG_W'((ONE + 64'd5) / 64'd10);
      gain <= CFG_W'(ONE);
      radius <= CFG_W'(64'd5 * ONE);
      push <= CFG_W'(ONE);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OBS_X:  obs_x <= cfg_data;
        REG_OBS_Y:  obs_y <= cfg_data;
        REG_DAMP:   damp <= cfg_data;
        REG_INV_M:  inv_m <= cfg_data;
        REG_STEP:   hstep <= cfg_data;
        REG_GAIN:   gain <= cfg_data;
        REG_RADIUS: radius <= cfg_data;
        REG_PUSH:   push <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic logic [63:0] ucap(input logic [63:0] v);
    return (v > CAP) ? CAP : v;
  endfunction

  // working registers
  logic signed [63:0] fx, fy, dx, dy;
  logic [63:0] ax, ay, dlen, inv_d, t_val, q_val, mag;
  logic        far;
  logic [63:0] u_num, u_den, u_res;
  logic        u_busy, div_start, sqrt_start;
  logic [63:0] prod;

  assign sts.busy = u_busy;
  assign sts.rep_ok = !far && (dlen != 0) && (dlen < {33'd0, radius});

  // iterative unit operand select
  always_comb begin
    u_num = '0;
    u_den = 64'd1;
    sqrt_start = cmd.sqrt_go;
    div_start = cmd.divd_go | cmd.divr_go | cmd.divm_go | cmd.compx_go | cmd.compy_go;
    if (cmd.sqrt_go) u_num = ax[31:0] * ax[31:0] + ay[31:0] * ay[31:0];
    if (cmd.divd_go) begin u_num = NUM; u_den = dlen; end
    if (cmd.divr_go) begin u_num = NUM; u_den = {33'd0, radius}; end
    if (cmd.divm_go) begin u_num = t_val << FRAC_BITS; u_den = q_val; end
    if (cmd.compx_go) begin u_num = mag[31:0] * ax[31:0]; u_den = dlen; end
    if (cmd.compy_go) begin u_num = mag[31:0] * ay[31:0]; u_den = dlen; end
  end

  pmr_divsqrt u_unit (
    .clk(clk), .rst(rst), .start_div(div_start), .start_sqrt(sqrt_start),
    .num(u_num), .den(u_den), .busy(u_busy), .res(u_res)
  );

  // sequencing of unit results
  typedef enum logic [2:0] {R_NONE, R_SQRT, R_DIVD, R_DIVR, R_DIVM, R_CX, R_CY} rsel_t;
  rsel_t rsel;
  logic  rpend;
  logic [63:0] diff;

  assign diff = (inv_d > ucap(u_res)) ? inv_d - ucap(u_res) : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpend <= 1'b0;
      rsel <= R_NONE;
    end else begin
      if (cmd.sqrt_go) begin rsel <= R_SQRT; rpend <= 1'b1; end
      else if (cmd.divd_go) begin rsel <= R_DIVD; rpend <= 1'b1; end
      else if (cmd.divr_go) begin rsel <= R_DIVR; rpend <= 1'b1; end
      else if (cmd.divm_go) begin rsel <= R_DIVM; rpend <= 1'b1; end
      else if (cmd.compx_go) begin rsel <= R_CX; rpend <= 1'b1; end
      else if (cmd.compy_go) begin rsel <= R_CY; rpend <= 1'b1; end
      else if (rpend && !u_busy) rpend <= 1'b0;
    end
    // push forces of the accepted word
    if (cmd.load) begin
      fx <= item[0] ? (item[2] ? $signed({33'd0, push}) : 64'sd0)
                      - (item[4] ? $signed({33'd0, push}) : 64'sd0) : 64'sd0;
      fy <= item[0] ? (item[3] ? $signed({33'd0, push}) : 64'sd0)
                      - (item[1] ? $signed({33'd0, push}) : 64'sd0) : 64'sd0;
    end
    if (rpend && !u_busy && !div_start && !sqrt_start) begin
      unique case (rsel)
        R_SQRT: dlen <= u_res;
        R_DIVD: inv_d <= ucap(u_res);
        R_DIVR: prod <= 64'(gain * diff[31:0]);
        // tiny distance: full magnitude whenever any repulsion is left
        R_DIVM: mag <= (q_val == 64'd0) ? ((t_val != 64'd0) ? CAP : 64'd0)
                                        : ucap(u_res);
        R_CX:   fx <= fx + (dx < 0 ? -$signed(u_res) : $signed(u_res));
        R_CY:   fy <= fy + (dy < 0 ? -$signed(u_res) : $signed(u_res));
        default: ;
      endcase
    end
    if (cmd.gain) begin
      t_val <= ucap(prod >> FRAC_BITS);
      q_val <= (dlen[31:0] * dlen[31:0]) >> FRAC_BITS;
    end
  end

  // axis step sequence: one product per cycle
  logic [3:0] ax_step;
  logic signed [63:0] acc;
  logic signed [63:0] ax_v, ax_f, ax_p;
  logic signed [63:0] mulres;
  logic signed [31:0] mopa, mopb;
  logic ax_sel;

  assign sts.axis_done = (ax_step == 4'd9);
  assign ax_v = ax_sel ? 64'(vel_y) : 64'(vel_x);
  assign ax_f = sat(ax_sel ? fy : fx);
  assign ax_p = ax_sel ? 64'(pos_y) : 64'(pos_x);

  always_comb begin
    mopa = 32'(acc);
    mopb = $signed({1'b0, hstep});
    unique case (ax_step[1:0])
      2'd0: begin mopa = 32'(ax_v); mopb = $signed({1'b0, damp}); end
      2'd1: begin mopa = 32'(acc); mopb = $signed({1'b0, inv_m}); end
      default: ;
    endcase
    mulres = mopa * mopb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= 32'(HOME);
      pos_y <= 32'(HOME);
      vel_x <= '0;
      vel_y <= '0;
      ax_step <= '0;
      ax_sel <= 1'b0;
    end else begin
      if (cmd.load && item[0] && item[5]) begin
        pos_x <= 32'(HOME);
        pos_y <= 32'(HOME);
        vel_x <= '0;
        vel_y <= '0;
      end
      if (cmd.prep) begin
        dx <= 64'(pos_x) - $signed({33'd0, obs_x});
        dy <= 64'(pos_y) - $signed({33'd0, obs_y});
        ax <= 64'(pos_x) - $signed({33'd0, obs_x}) < 0 ?
              64'($signed({33'd0, obs_x}) - 64'(pos_x)) :
              64'(64'(pos_x) - $signed({33'd0, obs_x}));
        ay <= 64'(pos_y) - $signed({33'd0, obs_y}) < 0 ?
              64'($signed({33'd0, obs_y}) - 64'(pos_y)) :
              64'(64'(pos_y) - $signed({33'd0, obs_y}));
        far <= 1'b0;
      end
      if (cmd.sqrt_go)
        far <= (ax >= 64'h8000_0000) || (ay >= 64'h8000_0000);
      if (cmd.axis && !sts.axis_done) begin
        unique case (ax_step)
          4'd0, 4'd4: acc <= sat(ax_f - (mulres >>> FRAC_BITS));
          4'd1, 4'd5: acc <= sat(mulres >>> FRAC_BITS);
          4'd2, 4'd6: acc <= sat(ax_v + sat(mulres >>> FRAC_BITS));
          default: begin
            acc <= sat(ax_p + (mulres >>> FRAC_BITS));
            if (ax_sel) begin
              vel_y <= 32'(acc);
              pos_y <= 32'(sat(ax_p + (mulres >>> FRAC_BITS)));
            end else begin
              vel_x <= 32'(acc);
              pos_x <= 32'(sat(ax_p + (mulres >>> FRAC_BITS)));
            end
          end
        endcase
        if (ax_step == 4'd3) begin
          ax_step <= 4'd4;
          ax_sel <= 1'b1;
        end else if (ax_step == 4'd7) begin
          ax_step <= 4'd9;
        end else begin
          ax_step <= ax_step + 4'd1;
        end
      end else if (cmd.commit) begin
        ax_step <= '0;
        ax_sel <= 1'b0;
      end
    end
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the point mass repulsion step unit
// Drives tick words on the input stream, predicts each command tick's state
// word with a local fixed-point model of the push, repulsion and damped Euler
// step, and compares every output word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import pmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FB       = DEF_FRAC_BITS;
  localparam longint CAP   = 64'sd2147483647;
  localparam longint MINV  = -64'sd2147483648;
  localparam longint HOME  = 64'sd10 <<< FB;
  localparam int  DRAIN_CYC = 500;
  localparam int  HOLD_CYC  = 3000;

  // input word bit positions
  localparam int B_CMD = 0, B_N = 1, B_E = 2, B_S = 3, B_W = 4, B_HOME = 5;

  typedef struct {
    longint px, py, vx, vy;
  } mass_state_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // has_command, push_north, push_east, push_south, push_west, home_request
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_pos_x, out_pos_y, out_vel_x, out_vel_y
  logic [127:0] m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  point_mass_repulsion_step_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and state
  longint      reg_val [8];
  mass_state_t mass;
  mass_state_t state_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_start = 1'b0;
  int          hold_left = 0;

  function automatic longint sat32(longint v);
    if (v > CAP) return CAP;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function automatic longint unsigned cap31(longint unsigned v);
    return (v > 64'd2147483647) ? 64'd2147483647 : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint rep_part(longint unsigned mag, longint delta,
                                      longint unsigned span);
    longint unsigned m;
    longint c;
    m = (delta < 0) ? longint'(-delta) : longint'(delta);
    c = longint'((mag * m) / span);
    return (delta < 0) ? -c : c;
  endfunction

  // damped Euler step on one axis
  task automatic axis_advance(inout longint p, inout longint v, input longint f);
    longint dmp, a, b, dv;
    dmp = (reg_val[REG_DAMP] * v) >>> FB;
    a   = sat32(f - dmp);
    b   = sat32((a * reg_val[REG_INV_M]) >>> FB);
    dv  = sat32((b * reg_val[REG_STEP]) >>> FB);
    v   = sat32(v + dv);
    p   = sat32(p + ((v * reg_val[REG_STEP]) >>> FB));
  endtask

  // one tick of the mass; queues the state word on command ticks
  task automatic predict_tick(input logic [7:0] w);
    longint fx, fy, dx, dy, pf;
    longint unsigned ax, ay, d, inv_d, inv_r, diff, t, q, mag, rad;
    fx = 0;
    fy = 0;
    pf = reg_val[REG_PUSH];
    rad = longint'(reg_val[REG_RADIUS]);
    if (w[B_CMD]) begin
      if (w[B_N]) fy -= pf;
      if (w[B_E]) fx += pf;
      if (w[B_S]) fy += pf;
      if (w[B_W]) fx -= pf;
      if (w[B_HOME]) begin
        mass.px = HOME; mass.py = HOME; mass.vx = 0; mass.vy = 0;
      end
    end
    dx = mass.px - reg_val[REG_OBS_X];
    dy = mass.py - reg_val[REG_OBS_Y];
    if (dx > MINV && dx <= CAP && dy > MINV && dy <= CAP) begin
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      d = int_sqrt(ax * ax + ay * ay);
      if (d > 0 && d < rad) begin
        inv_d = cap31((64'd1 << (2 * FB)) / d);
        inv_r = cap31((64'd1 << (2 * FB)) / rad);
        diff  = (inv_d > inv_r) ? inv_d - inv_r : 0;
        t     = cap31((longint'(reg_val[REG_GAIN]) * diff) >> FB);
        q     = (d * d) >> FB;
        if (q == 0) mag = (t > 0) ? 64'd2147483647 : 0;
        else        mag = cap31((t << FB) / q);
        fx += rep_part(mag, dx, d);
        fy += rep_part(mag, dy, d);
      end
    end
    fx = sat32(fx);
    fy = sat32(fy);
    axis_advance(mass.px, mass.vx, fx);
    axis_advance(mass.py, mass.vy, fy);
    if (w[B_CMD]) state_q.push_back(mass);
  endtask

  // send one tick word; predicts at acceptance
  task automatic send_tick(input logic [7:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
    predict_tick(w);
  endtask

  function automatic logic [7:0] tick_word(bit cmd, bit n, bit e, bit s, bit wst,
                                           bit hm);
    logic [7:0] w;
    w = '0;
    w[B_CMD] = cmd; w[B_N] = n; w[B_E] = e; w[B_S] = s; w[B_W] = wst;
    w[B_HOME] = hm;
    return w;
  endfunction

  // wait for all words, then for the tail of a tick that emits nothing
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (state_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input longint val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(posedge clk);
    reg_val[idx] = val & 64'h7FFF_FFFF;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stall plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = HOLD_CYC;
      hold_start <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // output checker
  always @(posedge clk) begin
    mass_state_t e;
    logic signed [31:0] got [4];
    logic signed [31:0] exp_f [4];
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      for (int i = 0; i < 4; i++) got[i] = m_axis_tdata[32*i +: 32];
      if (state_q.size() == 0) begin
        $display("%0t: unexpected state word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = state_q.pop_front();
        exp_f[0] = e.px[31:0]; exp_f[1] = e.py[31:0];
        exp_f[2] = e.vx[31:0]; exp_f[3] = e.vy[31:0];
        for (int i = 0; i < 4; i++)
          if (got[i] !== exp_f[i]) begin
            $display("%0t: field %0d expected %0d actual %0d", $time, i,
                     exp_f[i], got[i]);
            errors++;
          end
      end
    end
  end

  // each push bit, home, ignored bits without a command, on defaults
  task automatic test_default_ticks();
    send_tick(tick_word(1, 0, 0, 0, 0, 0));
    send_tick(tick_word(1, 1, 0, 0, 0, 0));
    send_tick(tick_word(1, 0, 1, 0, 0, 0));
    send_tick(tick_word(1, 0, 0, 1, 0, 0));
    send_tick(tick_word(1, 0, 0, 0, 1, 0));
    send_tick(tick_word(0, 1, 1, 1, 1, 1));
    send_tick(tick_word(1, 1, 1, 1, 1, 0));
    send_tick(tick_word(1, 0, 1, 0, 0, 1));
    drain();
  endtask

  // obstacle on the mass, tiny distance, extreme and zero registers
  task automatic test_register_extremes();
    write_reg(REG_OBS_X, HOME);
    write_reg(REG_OBS_Y, HOME);
    send_tick(tick_word(1, 0, 0, 0, 0, 1));
    drain();
    write_reg(REG_OBS_X, HOME + 100);
    send_tick(tick_word(1, 0, 0, 0, 0, 1));
    send_tick(tick_word(1, 0, 0, 0, 0, 0));
    drain();
    for (int i = 0; i < 8; i++) write_reg(i[IDX_W-1:0], CAP);
    send_tick(tick_word(1, 0, 1, 1, 0, 1));
    send_tick(tick_word(1, 0, 1, 1, 0, 0));
    send_tick(tick_word(1, 1, 0, 0, 1, 0));
    send_tick(tick_word(1, 1, 0, 0, 1, 0));
    drain();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_OBS_X, 64'sd11 <<< FB);
    write_reg(REG_OBS_Y, 64'sd10 <<< FB);
    send_tick(tick_word(1, 0, 0, 0, 0, 1));
    drain();
    for (int i = 0; i < 8; i++) write_reg(i[IDX_W-1:0], 0);
    send_tick(tick_word(1, 1, 1, 0, 0, 1));
    send_tick(tick_word(1, 0, 0, 1, 1, 0));
    drain();
  endtask

  function automatic longint pick_q(longint lo, longint hi);
    if ($urandom_range(19) == 0) return ($urandom_range(1) != 0) ? CAP : 0;
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  task automatic random_config();
    if ($urandom_range(9) == 0) begin
      write_reg(REG_OBS_X, {1'b0, $urandom} & 64'h7FFF_FFFF);
      write_reg(REG_OBS_Y, {1'b0, $urandom} & 64'h7FFF_FFFF);
    end else begin
      write_reg(REG_OBS_X, pick_q(0, 64'sd20 <<< FB));
      write_reg(REG_OBS_Y, pick_q(0, 64'sd20 <<< FB));
    end
    write_reg(REG_DAMP,   pick_q(0, 64'sd2 <<< FB));
    write_reg(REG_INV_M,  pick_q(0, 64'sd2 <<< FB));
    write_reg(REG_STEP,   pick_q(0, 64'sd1 <<< (FB - 2)));
    write_reg(REG_GAIN,   pick_q(0, 64'sd4 <<< FB));
    write_reg(REG_RADIUS, pick_q(1, 64'sd12 <<< FB));
    write_reg(REG_PUSH,   pick_q(0, 64'sd4 <<< FB));
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 6;  recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      random_config();
      for (int k = 0; k < 160; k++)
        send_tick(tick_word($urandom_range(9) < 7, 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), $urandom_range(9) == 0));
      drain();
    end
  endtask

  // long receiver hold-off while ticks keep coming
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_start <= 1'b1;
    for (int k = 0; k < 12; k++)
      send_tick(tick_word(1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), 0));
    drain();
  endtask

  initial begin
    reg_val[REG_OBS_X]  = 0;
    reg_val[REG_OBS_Y]  = 0;
    reg_val[REG_DAMP]   = 64'sd1 <<< FB;
    reg_val[REG_INV_M]  = 64'sd1 <<< FB;
    reg_val[REG_STEP]   = ((64'sd1 <<< FB) + 5) / 10;
    reg_val[REG_GAIN]   = 64'sd1 <<< FB;
    reg_val[REG_RADIUS] = 64'sd5 <<< FB;
    reg_val[REG_PUSH]   = 64'sd1 <<< FB;
    mass.px = HOME; mass.py = HOME; mass.vx = 0; mass.vy = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_ticks();
    test_register_extremes();
    test_output_stall();
    test_random_phases();
    if (errors == 0 && state_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### point_mass_repulsion_step_unit.f
+incdir+rtl/core
rtl/core/pmr_pkg.sv
rtl/core/pmr_ctrl.sv
rtl/core/pmr_divsqrt.sv
rtl/core/pmr_datapath.sv
rtl/core/point_mass_repulsion_step_unit.sv
verif/tb_top.sv
